>>> rtl/core/echo_range_moving_average_core_assert.svh
// Assertion macros used by the range core checker.
`ifndef ECHO_RANGE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define ECHO_RANGE_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ERA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ERA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/era_pkg.sv
// Shared constants, types and state encoding for the echo range core.
package era_pkg;

  // Field widths
  localparam int TICKS_W = 16;
  localparam int DIST_W  = 10;
  localparam int DIV_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register defaults
  localparam logic [TICKS_W-1:0] TPC_RESET   = 16'd117;
  localparam logic [DIST_W-1:0]  RANGE_RESET = 10'd400;
  localparam logic [DIST_W-1:0]  NEAR_RESET  = 10'd100;

  // Default ring length
  localparam int FILTER_DEPTH_DEFAULT = 5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICKS_PER_CM  = 2'd0,
    REG_MAX_RANGE_CM  = 2'd1,
    REG_NEAR_LIMIT_CM = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_ACCUM,
    S_LAUNCH,
    S_AVG,
    S_DONE
  } era_state_t;

  // Request into the serial divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/core/echo_range_moving_average_core.sv
// Echo pulse to distance conversion with a moving average over a cell chain.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_ready    | echo_ticks
//  out      | out_valid / out_ready  | raw_cm, filtered_cm, object_near
//  cfg      | cfg_we (write only)    | cfg_index, cfg_data
//
// Each item goes from accept to its loaded result through two passes of the
// 16-step serial divider (distance, then average) plus sequencing.
// The next item is accepted as soon as the result sits in the output
// register, even while it waits for out_ready.
// Reset clears the fill count, running sum, configuration registers and
// handshakes; the sample cells are never cleared and are only summed once written.
module echo_range_moving_average_core
  import era_pkg::*;
#(
  parameter int FILTER_DEPTH = FILTER_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TICKS_W-1:0]   echo_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIST_W-1:0]    raw_cm,
  output logic [DIST_W-1:0]    filtered_cm,
  output logic                 object_near,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(FILTER_DEPTH + 1);
  localparam int SUM_W = DIST_W + CNT_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FILTER_DEPTH);

  era_state_t state, state_next;

  logic [TICKS_W-1:0] ticks_per_cm;
  logic [DIST_W-1:0]  max_range_cm;
  logic [DIST_W-1:0]  near_limit_cm;

  logic               echo_zero;
  logic [DIST_W-1:0]  raw;
  logic [DIST_W-1:0]  filt;
  logic [CNT_W-1:0]   fill;
  logic [SUM_W-1:0]   sum;
  logic               ring_full;
  logic               shift;
  logic               load_out;

  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DIST_W-1:0]  raw_calc;
  logic [DIST_W-1:0]  chain [FILTER_DEPTH];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_cm  <= TPC_RESET;
      max_range_cm  <= RANGE_RESET;
      near_limit_cm <= NEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICKS_PER_CM:  ticks_per_cm  <= cfg_data[TICKS_W-1:0];
        REG_MAX_RANGE_CM:  max_range_cm  <= cfg_data[DIST_W-1:0];
        REG_NEAR_LIMIT_CM: near_limit_cm <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencing strobes
  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    shift            = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = echo_ticks;
    div_req.divisor  = ticks_per_cm;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          div_req.start = 1'b1;
          state_next    = S_DIST;
        end
      end
      S_DIST: begin
        if (div_done) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        shift      = 1'b1;
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(sum);
        div_req.divisor  = DIV_W'(fill);
        state_next       = S_AVG;
      end
      S_AVG: begin
        div_req.dividend = DIV_W'(sum);
        div_req.divisor  = DIV_W'(fill);
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Shared serial divider
  era_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Distance from quotient: zero for no echo or beyond range
  assign raw_calc = (echo_zero || (div_quo > DIV_W'(max_range_cm))) ?
                    '0 : div_quo[DIST_W-1:0];

  // Item working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      echo_zero <= (echo_ticks == '0);
    end
    if (state == S_DIST && div_done) begin
      raw <= raw_calc;
    end
    if (state == S_AVG && div_done) begin
      filt <= div_quo[DIST_W-1:0];
    end
  end

  // Sample chain: newest in cell 0, oldest in the last cell
  genvar g;
  generate
    for (g = 0; g < FILTER_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        era_cell u_cell (
          .clk   (clk),
          .shift (shift),
          .d_in  (raw),
          .d_out (chain[g])
        );
      end else begin : g_body
        era_cell u_cell (
          .clk   (clk),
          .shift (shift),
          .d_in  (chain[g-1]),
          .d_out (chain[g])
        );
      end
    end
  endgenerate

  // Fill count and running sum; the oldest sample drops out once full
  assign ring_full = (fill == FULL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
    end else if (shift) begin
      if (!ring_full) begin
        fill <= fill + 1'b1;
        sum  <= sum + SUM_W'(raw);
      end else begin
        sum  <= sum + SUM_W'(raw) - SUM_W'(chain[FILTER_DEPTH-1]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      raw_cm      <= raw;
      filtered_cm <= filt;
      object_near <= (filt != '0) && (filt < near_limit_cm);
    end
  end

endmodule

>>> rtl/core/era_cell.sv
// One sample cell of the averaging chain: loads the upstream sample on shift.
module era_cell
  import era_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [DIST_W-1:0] d_in,
  output logic [DIST_W-1:0] d_out
);

  logic [DIST_W-1:0] sample;

  // Sample register, takes the upstream value when the chain advances
  always_ff @(posedge clk) begin
    if (shift) begin
      sample <= d_in;
    end
  end

  assign d_out = sample;

endmodule

>>> rtl/core/era_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module era_divider
  import era_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

  logic             busy;
  logic [CNT_W-1:0] step;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction.
  // A zero divisor always fits, giving an all-ones quotient.
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, req.divisor});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(trial - {1'b0, req.divisor});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/era_checker.sv
// Port-level checker for the echo range core, bound to the top level.
`include "echo_range_moving_average_core_assert.svh"

module era_checker
  import era_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] raw_cm,
  input logic [DIST_W-1:0] filtered_cm,
  input logic              object_near
);

  // A held result keeps its payload
  `ERA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(raw_cm) && $stable(filtered_cm) && $stable(object_near), "stalled result changed")

  // Near flag only with a nonzero average
  `ERA_ASSERT_IMP(a_near_nonzero, clk, rst, out_valid && object_near, filtered_cm != '0, "near flag with zero average")

  // Busy with the item right after accept
  `ERA_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule

bind echo_range_moving_average_core era_checker u_era_checker (.*);
